### design/prlm_pkg.sv
`default_nettype none

package prlm_pkg;

    // table geometry
    localparam int MAX_RANGES = 64;
    localparam int PORT_BITS  = 16;
    localparam int IDX_BITS   = $clog2(MAX_RANGES);
    localparam int CNT_BITS   = $clog2(MAX_RANGES + 1);
    localparam int ENTRY_BITS = 2 * PORT_BITS;

    // stream payload widths, padded to whole bytes
    localparam int IN_TDATA_BITS  = ((3 * PORT_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 2;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // item kinds carried on tuser
    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef logic [PORT_BITS-1:0] t_port;
    typedef logic [CNT_BITS-1:0]  t_count;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPEND,
        ST_SCAN,
        ST_REPORT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic scan_step;
        logic append_commit;
        logic report_commit;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

### design/prlm_ram.sv
`default_nettype none

module prlm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/prlm_ctrl.sv
`default_nettype none

module prlm_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_valid,
    input  wire logic                 i_s_kind,
    input  wire prlm_pkg::t_dp_status i_status,
    output logic                      o_s_ready,
    output prlm_pkg::t_ctrl_cmd       o_cmd
);

    import prlm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_s_ready = 1'b0;
        o_cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_s_kind == KIND_LOOKUP) ? ST_SCAN : ST_APPEND;
                end
            end
            ST_APPEND: begin
                if (i_status.out_free) begin
                    o_cmd.append_commit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_done) begin
                    n_state = ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (i_status.out_free) begin
                    o_cmd.report_commit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/prlm_dp.sv
`default_nettype none

module prlm_dp (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire prlm_pkg::t_ctrl_cmd                    i_cmd,
    input  wire logic [prlm_pkg::IN_TDATA_BITS-1:0]     i_s_data,
    input  wire logic                                   i_m_ready,
    input  wire logic                                   i_cfg_valid,
    input  wire logic                                   i_cfg_data,
    output prlm_pkg::t_dp_status                        o_status,
    output logic                                        o_m_valid,
    output logic      [prlm_pkg::OUT_TDATA_BITS-1:0]    o_m_data
);

    import prlm_pkg::*;

    // captured item
    t_port  r_lo;
    t_port  r_hi;
    t_port  r_port;

    // table and scan state
    t_count r_count;
    t_count r_idx;
    logic   r_rd_vld;
    logic   r_hit;
    logic   r_invert;

    // result register
    logic   r_out_valid;
    logic   r_matched;
    logic   r_status;

    logic                  full;
    logic                  scan_done;
    logic                  out_free;
    logic                  issue;
    logic                  ram_we;
    logic [ENTRY_BITS-1:0] ram_rdata;
    t_port                 ent_lo;
    t_port                 ent_hi;
    logic                  ent_hit;

    assign full      = (r_count == t_count'(MAX_RANGES));
    assign scan_done = (r_idx >= r_count);
    assign out_free  = !r_out_valid || i_m_ready;
    assign issue     = i_cmd.scan_step && !scan_done;
    assign ram_we    = i_cmd.append_commit && !full;

    assign o_status.scan_done = scan_done;
    assign o_status.out_free  = out_free;

    prlm_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_RANGES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IDX_BITS-1:0]),
        .i_wdata ({r_hi, r_lo}),
        .i_raddr (r_idx[IDX_BITS-1:0]),
        .o_rdata (ram_rdata)
    );

    assign ent_lo  = ram_rdata[PORT_BITS-1:0];
    assign ent_hi  = ram_rdata[ENTRY_BITS-1:PORT_BITS];
    assign ent_hit = (ent_lo <= r_port) && (r_port <= ent_hi);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_lo   <= i_s_data[PORT_BITS-1:0];
            r_hi   <= i_s_data[2*PORT_BITS-1:PORT_BITS];
            r_port <= i_s_data[3*PORT_BITS-1:2*PORT_BITS];
        end
        if (i_cmd.append_commit || i_cmd.report_commit) begin
            r_matched <= i_cmd.report_commit ? (r_hit ^ r_invert) : 1'b0;
            r_status  <= (i_cmd.append_commit && full) ? STATUS_FULL : STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_invert    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_invert <= i_cfg_data;
            end
            if (ram_we) begin
                r_count <= r_count + t_count'(1);
            end
            r_rd_vld <= issue;
            if (i_cmd.capture) begin
                r_idx <= '0;
                r_hit <= 1'b0;
            end else begin
                if (issue) begin
                    r_idx <= r_idx + t_count'(1);
                end
                if (r_rd_vld && ent_hit) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.append_commit || i_cmd.report_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = {{(OUT_TDATA_BITS - OUT_FIELD_BITS){1'b0}}, r_status, r_matched};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(MAX_RANGES))
        else $error("entry count above table capacity");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_count)
        else $error("scan index ran past stored entries");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.append_commit && !full) |=> (r_count == $past(r_count) + t_count'(1)))
        else $error("accepted append did not add an entry");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.append_commit || i_cmd.report_commit) |-> out_free)
        else $error("result loaded over a pending transaction");

    a_read_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(i_cmd.scan_step))
        else $error("table read without scan step");

endmodule

`default_nettype wire

### design/port_range_list_matcher.sv
// port range list matcher
// s_axis carries one item per transaction: tuser is the kind (0 append, 1 lookup),
// tdata holds range_low, range_high and query_port. m_axis returns exactly one
// result per item: matched and status in tdata. a separate cfg channel writes the
// invert_match register. the user must write it only while the block is idle; the
// block itself does not enforce this. an append passes from acceptance through the
// APPEND state to the result register; a lookup scans the stored ranges one per
// cycle through the table memory read port, then loads its result from REPORT.
// one item is worked on at a time; the next is accepted once the previous result
// sits in the output register.
// reset empties the table (entry count zero) and clears invert_match; no clearing
// pass is needed since only entries below the count are ever read.
// when the receiver stalls, the result holds in the output register, one more item
// may be accepted and worked, and it waits before loading its own result.
`default_nettype none

module port_range_list_matcher (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // slave stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [15:0] range_low, [31:16] range_high, [47:32] query_port
    input  wire logic [prlm_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
    // [0] kind
    input  wire logic                                s_axis_tuser,
    // master stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [0] matched, [1] status, [7:2] zero
    output logic      [prlm_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    // configuration write channel, invert_match
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic                                i_cfg_data
);

    import prlm_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;
    logic       cfg_write;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    prlm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_kind  (s_axis_tuser),
        .i_status  (status),
        .o_s_ready (s_axis_tready),
        .o_cmd     (cmd)
    );

    prlm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_s_data    (s_axis_tdata),
        .i_m_ready   (m_axis_tready),
        .i_cfg_valid (cfg_write),
        .i_cfg_data  (i_cfg_data),
        .o_status    (status),
        .o_m_valid   (m_axis_tvalid),
        .o_m_data    (m_axis_tdata)
    );

endmodule

`default_nettype wire
